// ----- sv/nps_pkg.sv -----
// ============================================================================
// nps_pkg - shared types and constants for the nearest pose search table
// Command and status codes, item structs, and the op word that the front
// end hands to the back end through the op queue.
// ============================================================================
package nps_pkg;

    // Field widths fixed by the item format
    localparam int COORD_BITS      = 24;
    localparam int SLOT_W          = 10;
    localparam int FOUND_W         = 10;

    // Table depth default and the widest entry count the op word must carry
    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int OP_ARG_W        = 17;

    // Op queue between front and back end (power of two)
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        CMD_APPEND    = 2'd0,
        CMD_OVERWRITE = 2'd1,
        CMD_QUERY     = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                          cmd;
        logic signed [COORD_BITS-1:0]  pos_x;
        logic signed [COORD_BITS-1:0]  pos_y;
        logic signed [COORD_BITS-1:0]  heading;
        logic        [SLOT_W-1:0]      slot;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic [FOUND_W-1:0]     found_index;
    } t_result;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] h;
    } t_pose;

    // Classified op: arg is the table index for writes, the entry count for
    // a query; kind CMD_NONE carries a finished status with no table access.
    typedef struct packed {
        t_cmd                   kind;
        t_status                status;
        logic [OP_ARG_W-1:0]    arg;
        t_pose                  pose;
    } t_op;

endpackage

// ----- sv/nps_front.sv -----
// ============================================================================
// nps_front - command classifier
// Owns the entry count, checks each command against it and emits an op
// with its table index or scan length already resolved.
// ============================================================================
module nps_front
    import nps_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_op      o_q_data
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             accept;

    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;

    // Classify the command against the current entry count
    always_comb begin
        n_count             = r_count;
        o_q_data.kind       = i_item.cmd;
        o_q_data.status     = ST_OK;
        o_q_data.arg        = '0;
        o_q_data.pose.x     = i_item.pos_x;
        o_q_data.pose.y     = i_item.pos_y;
        o_q_data.pose.h     = i_item.heading;
        case (i_item.cmd)
            CMD_APPEND: begin
                if (r_count == CNT_W'(MAX_ENTRIES)) begin
                    o_q_data.kind   = CMD_NONE;
                    o_q_data.status = ST_FULL;
                end else begin
                    o_q_data.arg = OP_ARG_W'(r_count);
                    n_count      = CNT_W'(r_count + 1'b1);
                end
            end
            CMD_OVERWRITE: begin
                if (OP_ARG_W'(i_item.slot) >= OP_ARG_W'(r_count)) begin
                    o_q_data.kind   = CMD_NONE;
                    o_q_data.status = ST_BAD_INDEX;
                end else begin
                    o_q_data.arg = OP_ARG_W'(i_item.slot);
                end
            end
            CMD_QUERY: begin
                if (r_count == '0) begin
                    o_q_data.kind   = CMD_NONE;
                    o_q_data.status = ST_EMPTY;
                end else begin
                    o_q_data.arg = OP_ARG_W'(r_count);
                end
            end
            default: begin
                o_q_data.kind = CMD_NONE;
            end
        endcase
    end

    // Advance the entry count on an accepted append
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

endmodule

// ----- sv/nps_queue.sv -----
// ============================================================================
// nps_queue - short op queue
// Decouples the classifier from the table engine so each side stalls alone.
// ============================================================================
module nps_queue
    import nps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_op  o_data
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_op               r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Hold op payloads
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ----- sv/nps_back.sv -----
// ============================================================================
// nps_back - pose table engine
// Holds the pose memory, carries out writes and runs the nearest scan
// through a read / difference / square / sum / compare pipeline.
// ============================================================================
module nps_back
    import nps_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_op     i_q_data,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int MAG_W  = COORD_BITS;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Magnitude of the difference of two coordinates
    function automatic logic [MAG_W-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        logic        [DIFF_W-1:0] m;
        d = DIFF_W'(a) - DIFF_W'(b);
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return m[MAG_W-1:0];
    endfunction

    t_state             r_state;
    t_pose              r_mem [MAX_ENTRIES];
    t_pose              r_rd_data;
    t_pose              r_qry;
    logic [OP_ARG_W-1:0] r_len;
    logic [IDX_W-1:0]   r_rd_ptr;
    logic               r_issuing;

    logic               r_s0_v, r_s1_v, r_s2_v, r_s3_v;
    logic               r_s0_last, r_s1_last, r_s2_last, r_s3_last;
    logic [IDX_W-1:0]   r_s0_idx, r_s1_idx, r_s2_idx, r_s3_idx;
    logic [MAG_W-1:0]   r_mag_x, r_mag_y, r_mag_h;
    logic [SQ_W-1:0]    r_sq_x, r_sq_y, r_sq_h;
    logic [SUM_W-1:0]   r_s3_sum;

    logic               r_best_valid;
    logic [SUM_W-1:0]   r_best_sum;
    logic [IDX_W-1:0]   r_best_idx;

    logic               r_out_valid;
    t_result            r_out;

    logic               out_free;
    logic               take;
    logic               mem_we;
    logic               load_out;
    t_result            n_out;
    logic               issue_last;

    assign out_free   = !r_out_valid || i_pop;
    assign take       = (r_state == S_IDLE) && !i_q_empty && out_free;
    assign o_q_pop    = take;
    assign mem_we     = take && ((i_q_data.kind == CMD_APPEND) ||
                                 (i_q_data.kind == CMD_OVERWRITE));
    assign issue_last = ((OP_ARG_W'(r_rd_ptr) + OP_ARG_W'(1)) == r_len);
    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;

    // Pose memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_q_data.arg[IDX_W-1:0]] <= i_q_data.pose;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    // Select the next result
    always_comb begin
        load_out = 1'b0;
        n_out    = r_out;
        if (take) begin
            case (i_q_data.kind)
                CMD_APPEND, CMD_OVERWRITE: begin
                    load_out          = 1'b1;
                    n_out.status      = ST_OK;
                    n_out.found_index = FOUND_W'(i_q_data.arg);
                end
                CMD_QUERY: begin
                    load_out = 1'b0;
                end
                default: begin
                    load_out          = 1'b1;
                    n_out.status      = i_q_data.status;
                    n_out.found_index = '0;
                end
            endcase
        end else if ((r_state == S_DONE) && out_free) begin
            load_out          = 1'b1;
            n_out.status      = ST_OK;
            n_out.found_index = FOUND_W'(r_best_idx);
        end
    end

    // Hold the result until it is popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
        end
    end

    // Sequence ops and the scan address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issuing <= 1'b0;
            r_rd_ptr  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (take && (i_q_data.kind == CMD_QUERY)) begin
                        r_state   <= S_SCAN;
                        r_issuing <= 1'b1;
                        r_rd_ptr  <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_issuing) begin
                        if (issue_last) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_rd_ptr <= r_rd_ptr + 1'b1;
                        end
                    end
                    if (r_s3_v && r_s3_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Latch the query pose and scan length
    always_ff @(posedge i_clk) begin
        if (take && (i_q_data.kind == CMD_QUERY)) begin
            r_qry <= i_q_data.pose;
            r_len <= i_q_data.arg;
        end
    end

    // Scan pipeline valid tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s0_v <= (r_state == S_SCAN) && r_issuing;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    // Scan pipeline data: difference, square, sum
    always_ff @(posedge i_clk) begin
        r_s0_idx  <= r_rd_ptr;
        r_s0_last <= issue_last;

        r_s1_idx  <= r_s0_idx;
        r_s1_last <= r_s0_last;
        r_mag_x   <= abs_diff(r_rd_data.x, r_qry.x);
        r_mag_y   <= abs_diff(r_rd_data.y, r_qry.y);
        r_mag_h   <= abs_diff(r_rd_data.h, r_qry.h);

        r_s2_idx  <= r_s1_idx;
        r_s2_last <= r_s1_last;
        r_sq_x    <= SQ_W'(r_mag_x) * SQ_W'(r_mag_x);
        r_sq_y    <= SQ_W'(r_mag_y) * SQ_W'(r_mag_y);
        r_sq_h    <= SQ_W'(r_mag_h) * SQ_W'(r_mag_h);

        r_s3_idx  <= r_s2_idx;
        r_s3_last <= r_s2_last;
        r_s3_sum  <= SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_h);
    end

    // Keep the lowest index with the smallest distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
        end else if (take && (i_q_data.kind == CMD_QUERY)) begin
            r_best_valid <= 1'b0;
        end else if (r_s3_v) begin
            r_best_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_v && (!r_best_valid || (r_s3_sum < r_best_sum))) begin
            r_best_sum <= r_s3_sum;
            r_best_idx <= r_s3_idx;
        end
    end

    a_pipe_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v |-> (r_state == S_SCAN))
        else $error("scan pipeline active outside a scan");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE))
        else $error("op taken while engine busy");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_issuing) |-> (OP_ARG_W'(r_rd_ptr) < r_len))
        else $error("scan address beyond entry count");

    a_done_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_best_valid)
        else $error("scan finished without a candidate");

endmodule

// ----- sv/nearest_pose_search_table.sv -----
// ============================================================================
// nearest_pose_search_table - pose table with append, overwrite and query
// Stores planar poses and finds the stored pose nearest to a query pose by
// exact sum of squared differences in x, y and heading.
// Channels: a command transfers on a clock edge with push high and full low;
//   the oldest result sits on o_result while empty is low and transfers on
//   an edge with pop high. Every command gives one result, in command order.
// Result path: append, overwrite and rejected commands pass through the op queue
//   and the engine's result register. A query reads one stored pose per cycle,
//   then drains a read / difference / square / sum pipeline; its result is
//   registered once the last of the N stored poses has passed the compare.
// Throughput: one non-query command per cycle while results are popped; a query
//   holds the engine for its scan; the two-deep queue takes up to two commands.
// Reset: synchronous, active low; the entry count and control state clear.
//   The pose memory is not cleared, since only entries below the count are read.
// Stalls: while a result waits unpopped the engine holds; once the op queue
//   fills, full rises and commands are held off. Nothing is dropped.
// ============================================================================
module nearest_pose_search_table
    import nps_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output logic     empty,
    input  logic     pop,
    output t_result  o_result
);

    logic q_push;
    t_op  q_wr_data;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_op  q_rd_data;

    assign full = q_full;

    // Classify commands
    nps_front #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wr_data)
    );

    // Buffer classified ops
    nps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    // Execute ops against the pose table
    nps_back #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rd_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

// ----- test/tb.sv -----
// ============================================================================
// tb - self-checking bench for nearest_pose_search_table
// Sends append, overwrite, query and unused commands through the queue-style
// ports and keeps a local copy of the pose table to predict every result.
// Results are checked in order. The run covers the empty table, bad indices,
// distance ties, extreme coordinates and a long result stall.
// ============================================================================
module tb;
    import nps_pkg::*;

    localparam int TABLE_DEPTH  = DEF_MAX_ENTRIES;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int SMALL_ITEMS  = 495;
    localparam int HOLD_AT_ITEM = 150;
    localparam int TAIL_ITEMS   = 60;
    localparam int SMALL_CAP    = 48;
    localparam int MAX_PRINTS   = 40;

    localparam logic signed [COORD_BITS-1:0] C_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] C_NEG1 = '1;
    localparam logic signed [COORD_BITS-1:0] C_ZERO = '0;

    typedef struct {
        t_in_item item;
        bit       typed;
        t_result  res;
    } t_dir_row;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push    = 1'b0;
    logic     pop     = 1'b0;
    t_in_item i_item  = '0;
    logic     full;
    logic     empty;
    t_result  o_result;

    // local copy of the table and the results still owed by the block
    t_pose    model_poses [TABLE_DEPTH];
    int       model_count = 0;
    t_result  expected_results [$];
    t_dir_row directed_rows [$];

    int error_count     = 0;
    int cycle_count     = 0;
    int results_checked = 0;
    int n_append        = 0;
    int n_overwrite     = 0;
    int n_query         = 0;
    int n_unused        = 0;
    int n_full_stalls   = 0;
    bit quiet           = 1'b0;
    bit hold_request    = 1'b0;
    bit hold_active     = 1'b0;

    wire calm_window = ((cycle_count / 150) % 3) == 0;

    nearest_pose_search_table #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    // Free-running clock
    initial begin : clock_gen
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Count cycles, note input stalls and stop a hung run
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (push && full) n_full_stalls++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        if (error_count < MAX_PRINTS) $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Exact squared distance; each difference is at most 25 bits wide
    function automatic longint pose_distance(t_pose a, t_pose b);
        longint dx, dy, dh;
        dx = longint'(a.x) - longint'(b.x);
        dy = longint'(a.y) - longint'(b.y);
        dh = longint'(a.h) - longint'(b.h);
        return dx * dx + dy * dy + dh * dh;
    endfunction

    // Apply one command to the local table and return the result it owes
    function automatic t_result predict_table_command(t_in_item it);
        t_result r;
        t_pose   p;
        longint  best, d;
        r.status      = ST_OK;
        r.found_index = '0;
        p.x = it.pos_x;
        p.y = it.pos_y;
        p.h = it.heading;
        case (it.cmd)
            CMD_APPEND: begin
                if (model_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    model_poses[model_count] = p;
                    r.found_index = FOUND_W'(model_count);
                    model_count++;
                end
            end
            CMD_OVERWRITE: begin
                if (int'(it.slot) >= model_count) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    model_poses[it.slot] = p;
                    r.found_index = it.slot;
                end
            end
            CMD_QUERY: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // strict compare keeps the lowest index on a tie
                    best = pose_distance(model_poses[0], p);
                    for (int i = 1; i < model_count; i++) begin
                        d = pose_distance(model_poses[i], p);
                        if (d < best) begin
                            best = d;
                            r.found_index = FOUND_W'(i);
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        logic [31:0] r;
        r = $urandom();
        return r[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] near_coord(logic signed [COORD_BITS-1:0] c);
        int d;
        d = int'($urandom_range(0, 64)) - 32;
        return c + d[COORD_BITS-1:0];
    endfunction

    // Random command; most poses land on or near a stored pose
    function automatic t_in_item random_command(int append_weight);
        t_in_item it;
        t_pose    base;
        int       pick, mode;
        it.slot    = SLOT_W'($urandom());
        it.pos_x   = rand_coord();
        it.pos_y   = rand_coord();
        it.heading = rand_coord();
        pick = $urandom_range(0, 99);
        if (pick < append_weight)           it.cmd = CMD_APPEND;
        else if (pick < append_weight + 30) it.cmd = CMD_OVERWRITE;
        else if (pick < 95)                 it.cmd = CMD_QUERY;
        else                                it.cmd = CMD_NONE;
        // most overwrites hit a stored slot, the rest use a random slot that may lie past the count
        if (it.cmd == CMD_OVERWRITE && model_count > 0 && $urandom_range(0, 4) != 0)
            it.slot = SLOT_W'($urandom_range(0, model_count - 1));
        mode = $urandom_range(0, 3);
        if (model_count > 0 && mode != 0) begin
            base = model_poses[$urandom_range(0, model_count - 1)];
            if (mode == 1) begin
                it.pos_x   = base.x;
                it.pos_y   = base.y;
                it.heading = base.h;
            end else begin
                it.pos_x   = near_coord(base.x);
                it.pos_y   = near_coord(base.y);
                it.heading = near_coord(base.h);
            end
        end
        return it;
    endfunction

    // Offer one command and hold it until it transfers
    task automatic send_command(t_in_item it, bit typed, t_result typed_res);
        t_result predicted;
        i_item <= it;
        push   <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predicted = predict_table_command(it);
        expected_results.insert(expected_results.size(), typed ? typed_res : predicted);
        case (it.cmd)
            CMD_APPEND:    n_append++;
            CMD_OVERWRITE: n_overwrite++;
            CMD_QUERY:     n_query++;
            default:       n_unused++;
        endcase
    endtask

    // Drop push for a short random burst, except in calm stretches, the quiet tail or a hold
    task automatic sender_gap();
        int n;
        if (quiet || calm_window || hold_request || hold_active) return;
        if ($urandom_range(0, 4) != 0) return;
        n = $urandom_range(1, 4);
        push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic add_row(t_cmd c, logic signed [COORD_BITS-1:0] x,
                           logic signed [COORD_BITS-1:0] y,
                           logic signed [COORD_BITS-1:0] h,
                           logic [SLOT_W-1:0] s, bit typed, t_status st, int idx);
        t_dir_row row;
        row.item.cmd         = c;
        row.item.pos_x       = x;
        row.item.pos_y       = y;
        row.item.heading     = h;
        row.item.slot        = s;
        row.typed            = typed;
        row.res.status       = st;
        row.res.found_index  = FOUND_W'(idx);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic check_result(t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result status %0d index %0d with nothing pending",
                                      got.status, got.found_index));
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (got.status !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      results_checked, got.status, want.status));
        if (got.found_index !== want.found_index)
            report_mismatch($sformatf("result %0d: index %0d, expected %0d",
                                      results_checked, got.found_index, want.found_index));
    endtask

    // Result side: check each transfer, stall in bursts or for one long hold
    initial begin : result_sink
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) check_result(o_result);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
                pop <= 1'b1;
            end else if (!quiet && !calm_window && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                pop <= 1'b0;
                repeat (n) @(posedge i_clk);
                pop <= 1'b1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Command side: reset, directed table, random traffic, busy tail
    initial begin : command_source
        t_in_item it;
        t_result  none_res;
        none_res = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, unused command, extremes, ties and bad indices
        add_row(CMD_QUERY,     C_ZERO, C_ZERO, C_ZERO, '0, 1, ST_EMPTY, 0);
        add_row(CMD_OVERWRITE, C_ZERO, C_ZERO, C_ZERO, '0, 1, ST_BAD_INDEX, 0);
        add_row(CMD_NONE,      C_MAX,  C_MAX,  C_MAX,  '1, 1, ST_OK, 0);
        add_row(CMD_APPEND,    C_MAX,  C_MAX,  C_MAX,  '1, 1, ST_OK, 0);
        add_row(CMD_APPEND,    C_MIN,  C_MIN,  C_MIN,  '0, 1, ST_OK, 1);
        add_row(CMD_APPEND,    C_ZERO, C_ZERO, C_ZERO, '0, 1, ST_OK, 2);
        add_row(CMD_QUERY,     C_ZERO, C_ZERO, C_ZERO, '0, 1, ST_OK, 2);
        add_row(CMD_QUERY,     C_MAX,  C_MAX,  C_MAX,  '0, 1, ST_OK, 0);
        add_row(CMD_QUERY,     C_MIN,  C_MIN,  C_MIN,  '0, 1, ST_OK, 1);
        add_row(CMD_APPEND,    C_MAX,  C_MAX,  C_MAX,  '0, 1, ST_OK, 3);
        add_row(CMD_QUERY,     C_MAX,  C_MAX,  C_MAX,  '0, 1, ST_OK, 0);
        add_row(CMD_OVERWRITE, C_NEG1, C_NEG1, C_NEG1, 10'd3, 1, ST_OK, 3);
        add_row(CMD_OVERWRITE, C_ZERO, C_ZERO, C_ZERO, 10'd4, 1, ST_BAD_INDEX, 0);
        add_row(CMD_OVERWRITE, C_MIN,  C_MIN,  C_MIN,  '1, 1, ST_BAD_INDEX, 0);
        add_row(CMD_APPEND,    C_ZERO, C_ZERO, C_MAX,  '0, 1, ST_OK, 4);
        add_row(CMD_QUERY,     C_ZERO, C_ZERO, C_MAX - 24'sd100, '0, 0, ST_OK, 0);
        add_row(CMD_QUERY,     C_MAX,  C_MIN,  C_ZERO, '0, 0, ST_OK, 0);
        add_row(CMD_NONE,      C_MIN,  C_MIN,  C_MIN,  '0, 1, ST_OK, 0);
        add_row(CMD_OVERWRITE, C_ZERO, C_ZERO, C_ZERO, '0, 1, ST_OK, 0);
        add_row(CMD_QUERY,     C_ZERO, C_ZERO, C_ZERO, '0, 1, ST_OK, 0);
        add_row(CMD_QUERY,     24'sd1, C_NEG1, 24'sd1, '0, 0, ST_OK, 0);
        add_row(CMD_APPEND,    24'sh0ABCDE, 24'sh543210, 24'shF0F0F0, '0, 1, ST_OK, 5);
        add_row(CMD_QUERY,     24'sh0ABCD0, 24'sh543200, 24'shF0F000, '0, 0, ST_OK, 0);

        foreach (directed_rows[k]) begin
            send_command(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].res);
            sender_gap();
        end

        // random traffic on a small table, with one long result stall
        for (int k = 0; k < SMALL_ITEMS; k++) begin
            if (k == HOLD_AT_ITEM) hold_request = 1'b1;
            it = random_command(model_count < SMALL_CAP ? 30 : 4);
            send_command(it, 1'b0, none_res);
            sender_gap();
        end

        // no idling: last stored pose, a slot past the count, back-to-back traffic
        quiet = 1'b1;
        it.cmd     = CMD_QUERY;
        it.pos_x   = model_poses[model_count-1].x;
        it.pos_y   = model_poses[model_count-1].y;
        it.heading = model_poses[model_count-1].h;
        it.slot    = '0;
        send_command(it, 1'b0, none_res);
        it.cmd = CMD_OVERWRITE;
        it.slot = '1;
        send_command(it, 1'b0, none_res);
        for (int k = 0; k < TAIL_ITEMS; k++) send_command(random_command(15), 1'b0, none_res);
        push <= 1'b0;

        // wait for every owed result, then watch for strays
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d appends, %0d overwrites, %0d queries, %0d unused; checked %0d results",
                 n_append, n_overwrite, n_query, n_unused, results_checked);
        $display("Table held %0d of %0d poses at the end; input stalled on full for %0d cycles",
                 model_count, TABLE_DEPTH, n_full_stalls);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
